// ===== rtl/record_extent_sector_translator_top_defines.svh =====
// Assertion macros shared by the checker of the extent run translator.
`ifndef RECORD_EXTENT_SECTOR_TRANSLATOR_TOP_DEFINES_SVH
`define RECORD_EXTENT_SECTOR_TRANSLATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define REST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define REST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rest_pkg.sv =====
// Shared types and constants of the extent run translator.
package rest_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_RECORD_LOG2  = 2'd0;
    localparam logic [1:0] REG_CLUSTER_LOG2 = 2'd1;
    localparam logic [1:0] REG_SECTOR_LOG2  = 2'd2;
    localparam logic [1:0] REG_RUN_COUNT    = 2'd3;

    localparam logic [3:0] RESET_RECORD_LOG2  = 4'd10;
    localparam logic [4:0] RESET_CLUSTER_LOG2 = 5'd12;
    localparam logic [3:0] RESET_SECTOR_LOG2  = 4'd9;
    localparam logic [6:0] RESET_RUN_COUNT    = 7'd0;

    // Most sectors emitted for one record.
    localparam logic [3:0] MAX_SECT = 4'd8;

    localparam logic ACTION_LOAD      = 1'b0;
    localparam logic ACTION_TRANSLATE = 1'b1;

    typedef struct packed {
        logic [3:0] record_log2;
        logic [4:0] cluster_log2;
        logic [3:0] sector_log2;
        logic [6:0] run_count;
    } rest_cfg_t;

    typedef struct packed {
        logic        is_xlate;
        logic [5:0]  run_index;
        logic [47:0] run_start;
        logic [47:0] run_length;
        logic [62:0] first_sector;
        logic [3:0]  sect_log2;
        logic [4:0]  clus_log2;
        logic [4:0]  spc_log2;
        logic [3:0]  nsec;
        logic [6:0]  run_count;
    } rest_item_t;

    typedef struct packed {
        logic        valid;
        logic [62:0] offset;
        logic [2:0]  index;
        logic        not_found;
        logic        last;
    } rest_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_FIN,
        ST_MISS
    } rest_state_t;

endpackage

// ===== rtl/rest_fifo.sv =====
// Two-entry queue between the classifying front end and the run walker.
module rest_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rest_pkg::rest_item_t push_item,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output rest_pkg::rest_item_t head
);
    import rest_pkg::*;

    rest_item_t  mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/rest_front.sv =====
// Front end: accepts command words and works out the sector geometry.
module rest_front (
    input  logic                 start,
    input  logic                 full,
    input  logic                 action,
    input  logic [5:0]           run_index,
    input  logic [47:0]          run_start_cluster,
    input  logic [47:0]          run_length,
    input  logic [47:0]          record_num,
    input  rest_pkg::rest_cfg_t  cfg,
    output logic                 busy,
    output logic                 push,
    output rest_pkg::rest_item_t push_item
);
    import rest_pkg::*;

    logic [3:0] s_eff;
    logic [3:0] diff;
    logic [3:0] nsec_raw;
    logic [3:0] nsec;

    assign busy = full;
    assign push = start && !full;

    always_comb
    begin
        // The effective sector is the smallest of sector, record and cluster.
        s_eff = cfg.sector_log2;
        if (s_eff > cfg.record_log2)
        begin
            s_eff = cfg.record_log2;
        end
        if ({1'b0, s_eff} > cfg.cluster_log2)
        begin
            s_eff = cfg.cluster_log2[3:0];
        end
        diff     = cfg.record_log2 - s_eff;
        nsec_raw = (diff >= 4'd3) ? 4'd8 : (4'd1 << diff[1:0]);
        nsec     = (nsec_raw > MAX_SECT) ? MAX_SECT : nsec_raw;

        push_item.is_xlate     = (action == ACTION_TRANSLATE);
        push_item.run_index    = run_index;
        push_item.run_start    = run_start_cluster;
        push_item.run_length   = run_length;
        push_item.first_sector = 63'(record_num) << diff;
        push_item.sect_log2    = s_eff;
        push_item.clus_log2    = cfg.cluster_log2;
        push_item.spc_log2     = cfg.cluster_log2 - {1'b0, s_eff};
        push_item.nsec         = nsec;
        push_item.run_count    = cfg.run_count;
    end

endmodule

// ===== rtl/rest_back.sv =====
// Back end: run table memory and the sequencer that walks it per sector.
module rest_back #(
    parameter int MAX_RUNS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  rest_pkg::rest_item_t   head,
    output logic                   pop,
    output rest_pkg::rest_result_t result
);
    import rest_pkg::*;

    localparam int ADDR_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CNT_W  = $clog2(MAX_RUNS + 1);

    logic [95:0]       run_mem [MAX_RUNS];
    logic [95:0]       rd_data_reg;

    rest_state_t       state_reg;
    rest_state_t       state_next;
    rest_item_t        item_reg;
    rest_item_t        item_next;
    logic [2:0]        sec_reg;
    logic [2:0]        sec_next;
    logic [CNT_W-1:0]  run_reg;
    logic [CNT_W-1:0]  run_next;
    logic [CNT_W-1:0]  runs_reg;
    logic [CNT_W-1:0]  runs_next;
    logic [63:0]       vcn_reg;
    logic [63:0]       vcn_next;
    logic [63:0]       cluster_reg;
    logic [63:0]       cluster_next;
    logic [30:0]       within_reg;
    logic [30:0]       within_next;
    logic [62:0]       base_reg;
    logic [62:0]       base_next;
    rest_result_t      result_reg;
    rest_result_t      result_next;

    logic              mem_we;
    logic              mem_re;
    logic [CNT_W-1:0]  rd_idx;
    logic [15:0]       wr_idx_wide;
    logic [63:0]       abs_sector;
    logic [63:0]       in_shift;
    logic [63:0]       run_end;
    logic              hit;
    logic [CNT_W-1:0]  run_inc;
    logic              sec_last;

    assign result      = result_reg;
    assign wr_idx_wide = 16'(head.run_index);
    assign abs_sector  = {1'b0, item_reg.first_sector} + 64'(sec_reg);
    assign in_shift    = abs_sector << item_reg.sect_log2;
    assign run_end     = vcn_reg + 64'(rd_data_reg[47:0]);
    assign hit         = (cluster_reg < run_end);
    assign run_inc     = run_reg + CNT_W'(1);
    assign sec_last    = (({1'b0, sec_reg} + 4'd1) == item_reg.nsec);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            run_mem[wr_idx_wide[ADDR_W-1:0]] <= {head.run_start, head.run_length};
        end
        if (mem_re)
        begin
            rd_data_reg <= run_mem[rd_idx[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && head.is_xlate)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = (runs_reg == '0) ? ST_MISS : ST_WALK;
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    state_next = ST_FIN;
                end
                else if (run_inc == runs_reg)
                begin
                    state_next = ST_MISS;
                end
            end
            ST_FIN:
            begin
                state_next = sec_last ? ST_IDLE : ST_START;
            end
            ST_MISS:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        rd_idx       = '0;
        item_next    = item_reg;
        sec_next     = sec_reg;
        run_next     = run_reg;
        runs_next    = runs_reg;
        vcn_next     = vcn_reg;
        cluster_next = cluster_reg;
        within_next  = within_reg;
        base_next    = base_reg;
        result_next  = result_reg;
        result_next.valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (!head.is_xlate)
                    begin
                        mem_we = (32'(head.run_index) < MAX_RUNS);
                    end
                    item_next = head;
                    sec_next  = 3'd0;
                    if (32'(head.run_count) > MAX_RUNS)
                    begin
                        runs_next = CNT_W'(MAX_RUNS);
                    end
                    else
                    begin
                        runs_next = CNT_W'(head.run_count);
                    end
                end
            end
            ST_START:
            begin
                cluster_next = abs_sector >> item_reg.spc_log2;
                // Byte position inside the cluster keeps only the low cluster bits.
                within_next  = 31'(in_shift & ~(64'hFFFF_FFFF_FFFF_FFFF << item_reg.clus_log2));
                vcn_next     = 64'd0;
                run_next     = '0;
                mem_re       = (runs_reg != '0);
                rd_idx       = '0;
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    base_next = 63'(64'(rd_data_reg[95:48]) + cluster_reg - vcn_reg);
                end
                else
                begin
                    vcn_next = run_end;
                    run_next = run_inc;
                    if (run_inc != runs_reg)
                    begin
                        mem_re = 1'b1;
                        rd_idx = run_inc;
                    end
                end
            end
            ST_FIN:
            begin
                result_next.valid     = 1'b1;
                result_next.offset    = (base_reg << item_reg.clus_log2) + 63'(within_reg);
                result_next.index     = sec_reg;
                result_next.not_found = 1'b0;
                result_next.last      = sec_last;
                sec_next              = sec_reg + 3'd1;
            end
            ST_MISS:
            begin
                result_next.valid     = 1'b1;
                result_next.offset    = 63'd0;
                result_next.index     = sec_reg;
                result_next.not_found = 1'b1;
                result_next.last      = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg              <= item_next;
        sec_reg               <= sec_next;
        run_reg               <= run_next;
        runs_reg              <= runs_next;
        vcn_reg               <= vcn_next;
        cluster_reg           <= cluster_next;
        within_reg            <= within_next;
        base_reg              <= base_next;
    end

endmodule

// ===== rtl/record_extent_sector_translator_top.sv =====
// Top level of the extent run translator: register port, front end, queue, walker.
//
// A command word is taken on a rising edge with start high and busy low. A load
// word (action 0) writes one run entry and gives no result; a translate word
// (action 1) gives one result per sector of the record, up to eight, with last
// set on the final one, or stops early with a single not_found result.
// Words pass through a two-entry queue, so busy rises only when it is full.
// Each result shows for one cycle with result_valid high; the receiver cannot
// hold it off, and results of consecutive cycles never occur.
// A translate word is dequeued; then each sector passes a setup step, one walk
// step for each run visited up to the covering run, and a step that forms the
// offset into a registered result. The walk reads the run table memory one
// entry per cycle. A load word writes its run entry as it is dequeued.
// Registers at byte addresses 0, 4, 8, 12 are to be written by the user only
// while idle; the block itself does not enforce it. Reads return their values.
// Reset restores the register defaults and empties the queue; the run table
// holds no defined contents until loaded.
module record_extent_sector_translator_top #(
    parameter int MAX_RUNS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [5:0]  run_index,
    input  logic [47:0] run_start_cluster,
    input  logic [47:0] run_length,
    input  logic [47:0] record_num,
    output logic        result_valid,
    output logic [62:0] byte_offset,
    output logic [2:0]  sector_index,
    output logic        not_found,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rest_pkg::*;

    rest_cfg_t    cfg_reg;
    rest_cfg_t    cfg_next;
    logic         cfg_we;
    logic         fifo_full;
    logic         push;
    rest_item_t   push_item;
    logic         pop;
    logic         head_valid;
    rest_item_t   head;
    rest_result_t result;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (paddr[3:2])
                REG_RECORD_LOG2:  cfg_next.record_log2  = pwdata[3:0];
                REG_CLUSTER_LOG2: cfg_next.cluster_log2 = pwdata[4:0];
                REG_SECTOR_LOG2:  cfg_next.sector_log2  = pwdata[3:0];
                REG_RUN_COUNT:    cfg_next.run_count    = pwdata[6:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_RECORD_LOG2:  prdata = 32'(cfg_reg.record_log2);
            REG_CLUSTER_LOG2: prdata = 32'(cfg_reg.cluster_log2);
            REG_SECTOR_LOG2:  prdata = 32'(cfg_reg.sector_log2);
            REG_RUN_COUNT:    prdata = 32'(cfg_reg.run_count);
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.record_log2  <= RESET_RECORD_LOG2;
            cfg_reg.cluster_log2 <= RESET_CLUSTER_LOG2;
            cfg_reg.sector_log2  <= RESET_SECTOR_LOG2;
            cfg_reg.run_count    <= RESET_RUN_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rest_front u_front (
        .start             (start),
        .full              (fifo_full),
        .action            (action),
        .run_index         (run_index),
        .run_start_cluster (run_start_cluster),
        .run_length        (run_length),
        .record_num        (record_num),
        .cfg               (cfg_reg),
        .busy              (busy),
        .push              (push),
        .push_item         (push_item)
    );

    rest_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (fifo_full),
        .head_valid (head_valid),
        .head       (head)
    );

    rest_back #(
        .MAX_RUNS (MAX_RUNS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

    assign result_valid = result.valid;
    assign byte_offset  = result.offset;
    assign sector_index = result.index;
    assign not_found    = result.not_found;
    assign last         = result.last;

endmodule

// ===== rtl/rest_checker.sv =====
// Port-level checker of the extent run translator and its bind.
`include "record_extent_sector_translator_top_defines.svh"

module rest_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic [62:0] byte_offset,
    input logic        not_found,
    input logic        last,
    input logic        pready
);

    // A failed lookup always ends the record.
    `REST_ASSERT_IMP(a_nf_last, result_valid && not_found, last, "not_found without last")
    `REST_ASSERT_IMP(a_nf_zero, result_valid && not_found, byte_offset == 63'd0, "nonzero offset on error")
    // Each result is preceded by a setup state after the previous result.
    `REST_ASSERT_NXT(a_gap, result_valid, !result_valid, "results in back-to-back cycles")
    `REST_ASSERT_IMP(a_ready, 1'b1, pready, "pready dropped")

endmodule

bind record_extent_sector_translator_top rest_checker u_rest_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .byte_offset  (byte_offset),
    .not_found    (not_found),
    .last         (last),
    .pready       (pready)
);

// ===== bench/tb_record_extent_sector_translator_top.sv =====
// Self-checking testbench for the extent run record-to-sector translator.
`timescale 1ns / 1ps

module tb_record_extent_sector_translator_top;
    import rest_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS   = 13;
    localparam int SHOWN_ERRORS  = 10;

    typedef struct packed {
        logic [62:0] offset;
        logic [2:0]  sector;
        logic        miss;
        logic        last;
    } sector_result_t;

    // Holds a copy of the run table and the geometry registers, and the
    // sector offsets still owed by the block, oldest first.
    class sector_scoreboard;
        int unsigned rec_log2;
        int unsigned clus_log2;
        int unsigned sect_log2;
        int unsigned runs_valid;
        logic [47:0] run_starts [TABLE_DEPTH];
        logic [47:0] run_lengths [TABLE_DEPTH];
        sector_result_t offsets_due [$];
        int unsigned errors;

        function new();
            rec_log2   = RESET_RECORD_LOG2;
            clus_log2  = RESET_CLUSTER_LOG2;
            sect_log2  = RESET_SECTOR_LOG2;
            runs_valid = RESET_RUN_COUNT;
            errors     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_RECORD_LOG2:  rec_log2   = value[3:0];
                REG_CLUSTER_LOG2: clus_log2  = value[4:0];
                REG_SECTOR_LOG2:  sect_log2  = value[3:0];
                REG_RUN_COUNT:    runs_valid = value[6:0];
                default: ;
            endcase
        endfunction

        // The sector used is never larger than a record or a cluster.
        function void geometry(output int unsigned s_eff, output int unsigned diff,
                               output int unsigned spc);
            s_eff = sect_log2;
            if (s_eff > rec_log2) s_eff = rec_log2;
            if (s_eff > clus_log2) s_eff = clus_log2;
            diff = rec_log2 - s_eff;
            spc  = clus_log2 - s_eff;
        endfunction

        function int unsigned walk_limit();
            return (runs_valid > TABLE_DEPTH) ? TABLE_DEPTH : runs_valid;
        endfunction

        function logic [63:0] covered_clusters();
            logic [63:0] total;
            total = '0;
            for (int unsigned i = 0; i < walk_limit(); i++) total += run_lengths[i];
            return total;
        endfunction

        function void note_word(logic act, logic [5:0] idx, logic [47:0] first_cl,
                                logic [47:0] len, logic [47:0] rec);
            int unsigned s_eff, diff, spc, nsec, runs;
            logic [63:0] first_sec, abs_sec, cluster, vcn, offset;
            bit hit;
            sector_result_t entry;
            if (act == ACTION_LOAD) begin
                run_starts[idx]  = first_cl;
                run_lengths[idx] = len;
                return;
            end
            geometry(s_eff, diff, spc);
            nsec = (diff >= 4) ? 16 : (1 << diff);
            if (nsec > MAX_SECT) nsec = MAX_SECT;
            runs = walk_limit();
            first_sec = 64'(rec) << diff;
            for (int unsigned sec = 0; sec < nsec; sec++) begin
                abs_sec = first_sec + sec;
                cluster = abs_sec >> spc;
                vcn     = '0;
                offset  = '0;
                hit     = 1'b0;
                for (int unsigned i = 0; i < runs; i++) begin
                    if (cluster < vcn + run_lengths[i]) begin
                        offset = ((run_starts[i] + cluster - vcn) << clus_log2)
                               + ((abs_sec << s_eff) & ((64'd1 << clus_log2) - 64'd1));
                        hit = 1'b1;
                        break;
                    end
                    vcn += run_lengths[i];
                end
                // A miss ends the record with a single error word.
                if (!hit) begin
                    entry = '{63'd0, 3'(sec), 1'b1, 1'b1};
                    offsets_due.insert(offsets_due.size(), entry);
                    return;
                end
                entry = '{offset[62:0], 3'(sec), 1'b0, (sec + 1 == nsec)};
                offsets_due.insert(offsets_due.size(), entry);
            end
        endfunction

        function void check_result(logic [62:0] offset, logic [2:0] sector, logic miss,
                                   logic last);
            sector_result_t got, want;
            got = '{offset, sector, miss, last};
            if (offsets_due.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("mismatch: unexpected word offset %h sector %0d not_found %b last %b",
                             got.offset, got.sector, got.miss, got.last);
                return;
            end
            want = offsets_due.pop_front();
            if (got.offset !== want.offset || got.sector !== want.sector ||
                got.miss !== want.miss || got.last !== want.last) begin
                errors++;
                if (errors <= SHOWN_ERRORS) begin
                    $display("mismatch: expected offset %h sector %0d not_found %b last %b",
                             want.offset, want.sector, want.miss, want.last);
                    $display("          got      offset %h sector %0d not_found %b last %b",
                             got.offset, got.sector, got.miss, got.last);
                end
            end
        endfunction

        function int unsigned pending();
            return offsets_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        action = 1'b0;
    logic [5:0]  run_index = '0;
    logic [47:0] run_start_cluster = '0;
    logic [47:0] run_length = '0;
    logic [47:0] record_num = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        busy;
    logic        result_valid;
    logic [62:0] byte_offset;
    logic [2:0]  sector_index;
    logic        not_found;
    logic        last;
    logic [31:0] prdata;
    logic        pready;

    int unsigned idle_pct = 0;
    sector_scoreboard sb;

    record_extent_sector_translator_top #(
        .MAX_RUNS(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .run_index(run_index),
        .run_start_cluster(run_start_cluster),
        .run_length(run_length),
        .record_num(record_num),
        .result_valid(result_valid),
        .byte_offset(byte_offset),
        .sector_index(sector_index),
        .not_found(not_found),
        .last(last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_result(byte_offset, sector_index, not_found, last);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Start stays high when the next word follows without a gap.
    task automatic send_word(logic act, logic [5:0] idx, logic [47:0] first_cl,
                             logic [47:0] len, logic [47:0] rec);
        int unsigned gap;
        start             <= 1'b1;
        action            <= act;
        run_index         <= idx;
        run_start_cluster <= first_cl;
        run_length        <= len;
        record_num        <= rec;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_word(act, idx, first_cl, len, rec);
        gap = 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every owed word has come and the queue has drained any loads.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_setting(int unsigned r, int unsigned c, int unsigned s,
                                 int unsigned n);
        settle();
        write_reg(REG_RECORD_LOG2, r);
        write_reg(REG_CLUSTER_LOG2, c);
        write_reg(REG_SECTOR_LOG2, s);
        write_reg(REG_RUN_COUNT, n);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Record numbers are aimed mostly inside the mapped span and near its end.
    task automatic random_word();
        logic [63:0] pick, span;
        logic [47:0] len;
        int unsigned s_eff, diff, spc, sel;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            sel = $urandom_range(99);
            if (sel < 4) len = 48'(rand64());
            else if (sel < 12) len = '0;
            else len = 48'($urandom_range(1, 12));
            send_word(ACTION_LOAD, 6'($urandom_range(63)), 48'(rand64()), len,
                      48'(rand64()));
        end
        else
        begin
            sb.geometry(s_eff, diff, spc);
            span = sb.covered_clusters() << spc;
            sel = $urandom_range(99);
            if (sel < 12) pick = rand64();
            else if (sel < 30) pick = (span > 8) ? span - $urandom_range(8) : '0;
            else pick = rand64() % (span + (span >> 3) + 64'd16);
            if (sel >= 12) pick = pick >> diff;
            send_word(ACTION_TRANSLATE, 6'($urandom_range(63)), 48'(rand64()),
                      48'(rand64()), 48'(pick));
        end
    endtask

    initial
    begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every entry is loaded first so that no walk reads an unwritten one.
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_word(ACTION_LOAD, 6'(i), 48'(rand64()), 48'($urandom_range(1, 6)),
                      48'(rand64()));

        // With no valid runs every record misses on its first sector.
        send_word(ACTION_TRANSLATE, 6'd0, '0, '0, '0);
        send_word(ACTION_TRANSLATE, 6'd63, '1, '1, '1);

        apply_setting(10, 12, 9, 4);
        send_word(ACTION_LOAD, 6'd0, '1, 48'd1, '0);
        send_word(ACTION_LOAD, 6'd1, '0, '0, '1);
        send_word(ACTION_LOAD, 6'd2, 48'd123, 48'd3, '0);
        send_word(ACTION_LOAD, 6'd3, 48'h8000_0000_0000, '1, '0);
        send_word(ACTION_LOAD, 6'd63, '1, '1, '1);
        send_word(ACTION_TRANSLATE, '0, '0, '0, 48'd0);
        send_word(ACTION_TRANSLATE, '0, '0, '0, 48'd4);
        send_word(ACTION_TRANSLATE, '1, '1, '1, '1);

        // Sector wider than the cluster; the record runs off the end midway.
        apply_setting(12, 9, 12, 3);
        send_word(ACTION_TRANSLATE, '0, '0, '0, 48'd0);
        send_word(ACTION_TRANSLATE, '0, '0, '0, 48'd1);
        send_word(ACTION_TRANSLATE, '1, '1, '1, '1);

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: apply_setting(8, 9, 9, 64);
                1: apply_setting(12, 16, 9, $urandom_range(1, 63));
                2: apply_setting(12, 9, 12, 64);
                3: apply_setting(8, 16, 12, 1);
                4: apply_setting($urandom_range(8, 12), $urandom_range(9, 16),
                                 $urandom_range(9, 12), $urandom_range(0, 64));
                5: apply_setting(12, 16, 12, 64);
                default: apply_setting(12, 16, 9, 64);
            endcase
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 83;
                default: idle_pct = 8;
            endcase
            repeat (PHASE_WORDS) random_word();
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rest_pkg.sv
rtl/rest_fifo.sv
rtl/rest_front.sv
rtl/rest_back.sv
rtl/record_extent_sector_translator_top.sv
rtl/rest_checker.sv
bench/tb_record_extent_sector_translator_top.sv
